@@ hw/rtl/lsau_pkg.sv @@
// lsau_pkg: request codes, access sizes, merge masks and the stage word
// shared by the load/store align unit; no dependencies
`timescale 1ns / 1ps

package lsau_pkg;

  typedef enum logic [3:0] {
    REQ_LB  = 4'd0,
    REQ_LBU = 4'd1,
    REQ_LH  = 4'd2,
    REQ_LHU = 4'd3,
    REQ_LUI = 4'd4,
    REQ_LW  = 4'd5,
    REQ_LWL = 4'd6,
    REQ_LWR = 4'd7,
    REQ_SB  = 4'd8,
    REQ_SH  = 4'd9,
    REQ_SW  = 4'd10,
    REQ_SWL = 4'd11,
    REQ_SWR = 4'd12
  } req_e;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } size_e;

  localparam logic [31:0] WORD_ALIGN_MASK = 32'hFFFF_FFFC;
  localparam logic [31:0] LOW3_MASK       = 32'h00FF_FFFF;
  localparam logic [31:0] HIGH3_MASK      = 32'hFFFF_FF00;
  localparam logic [4:0]  SHIFT_TOP       = 5'd24;

  // word held after the address stage
  typedef struct packed {
    req_e        req_type;
    logic [31:0] ea;
    logic [15:0] off16;
    logic [31:0] rt;
    logic [31:0] mem;
    logic        fault;
  } addr_word_t;

endpackage

@@ hw/rtl/lsau_datapath.sv @@
// lsau_datapath: decode/merge stage and write-enable/output stage
// of the load/store align unit; uses lsau_pkg
`timescale 1ns / 1ps

module lsau_datapath import lsau_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  addr_word_t  word_i,
  output logic        done_o,
  output logic [31:0] access_address_o,
  output logic [1:0]  access_size_o,
  output logic        mem_read_o,
  output logic        mem_write_en_o,
  output logic [31:0] mem_write_data_o,
  output logic        reg_write_en_o,
  output logic [31:0] reg_value_o
);

  logic        valid2_q;
  logic [31:0] addr_d, addr_q;
  logic [1:0]  size_d, size_q;
  logic        rd_d, rd_q;
  logic        ren_d, ren_q;
  logic        store_d, store_q;
  logic        cancel_d, cancel_q;
  logic [31:0] wdata_d, wdata_q;
  logic [31:0] rval_d, rval_q;

  logic [4:0]  lsh;
  logic [4:0]  rsh;
  logic [31:0] waddr;

  logic        done_q;
  logic [31:0] out_addr_q;
  logic [1:0]  out_size_q;
  logic        out_rd_q;
  logic        out_wen_q;
  logic [31:0] out_wdata_q;
  logic        out_ren_q;
  logic [31:0] out_rval_q;

  assign lsh   = {word_i.ea[1:0], 3'b000};
  assign rsh   = SHIFT_TOP - lsh;
  assign waddr = word_i.ea & WORD_ALIGN_MASK;

  always_comb begin
    addr_d   = '0;
    size_d   = SIZE_BYTE;
    rd_d     = 1'b0;
    ren_d    = 1'b0;
    store_d  = 1'b0;
    wdata_d  = '0;
    rval_d   = '0;
    cancel_d = word_i.fault;
    case (word_i.req_type)
      REQ_LB: begin
        addr_d = word_i.ea; size_d = SIZE_BYTE; rd_d = 1'b1; ren_d = 1'b1;
        rval_d = {{24{word_i.mem[7]}}, word_i.mem[7:0]};
      end
      REQ_LBU: begin
        addr_d = word_i.ea; size_d = SIZE_BYTE; rd_d = 1'b1; ren_d = 1'b1;
        rval_d = {24'd0, word_i.mem[7:0]};
      end
      REQ_LH: begin
        addr_d = word_i.ea; size_d = SIZE_HALF; rd_d = 1'b1; ren_d = 1'b1;
        rval_d = {{16{word_i.mem[15]}}, word_i.mem[15:0]};
      end
      REQ_LHU: begin
        addr_d = word_i.ea; size_d = SIZE_HALF; rd_d = 1'b1; ren_d = 1'b1;
        rval_d = {16'd0, word_i.mem[15:0]};
      end
      REQ_LUI: begin
        ren_d    = 1'b1;
        cancel_d = 1'b0;
        rval_d   = {word_i.off16, 16'd0};
      end
      REQ_LW: begin
        addr_d = word_i.ea; size_d = SIZE_WORD; rd_d = 1'b1; ren_d = 1'b1;
        rval_d = word_i.mem;
      end
      REQ_LWL: begin
        addr_d = waddr; size_d = SIZE_WORD; rd_d = 1'b1; ren_d = 1'b1;
        rval_d = (word_i.rt & (LOW3_MASK >> lsh)) | (word_i.mem << rsh);
      end
      REQ_LWR: begin
        addr_d = waddr; size_d = SIZE_WORD; rd_d = 1'b1; ren_d = 1'b1;
        rval_d = (word_i.rt & (HIGH3_MASK << rsh)) | (word_i.mem >> lsh);
      end
      REQ_SB: begin
        addr_d = word_i.ea; size_d = SIZE_BYTE; store_d = 1'b1;
        wdata_d = {24'd0, word_i.rt[7:0]};
      end
      REQ_SH: begin
        addr_d = word_i.ea; size_d = SIZE_HALF; store_d = 1'b1;
        wdata_d = {16'd0, word_i.rt[15:0]};
      end
      REQ_SW: begin
        addr_d = word_i.ea; size_d = SIZE_WORD; store_d = 1'b1;
        wdata_d = word_i.rt;
      end
      REQ_SWL: begin
        addr_d = waddr; size_d = SIZE_WORD; rd_d = 1'b1; store_d = 1'b1;
        wdata_d = (word_i.rt >> rsh) | (word_i.mem & (HIGH3_MASK << lsh));
      end
      REQ_SWR: begin
        addr_d = waddr; size_d = SIZE_WORD; rd_d = 1'b1; store_d = 1'b1;
        wdata_d = (word_i.rt << lsh) | (word_i.mem & (LOW3_MASK >> rsh));
      end
      default: begin
        cancel_d = 1'b0;
      end
    endcase
  end

  // merge stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
    end else begin
      valid2_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    size_q   <= size_d;
    rd_q     <= rd_d;
    ren_q    <= ren_d;
    store_q  <= store_d;
    cancel_q <= cancel_d;
    wdata_q  <= wdata_d;
    rval_q   <= rval_d;
  end

  // output stage: a fault drops the writes and their data, but never a LUI's
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_addr_q  <= addr_q;
    out_size_q  <= size_q;
    out_rd_q    <= rd_q;
    out_wen_q   <= store_q & ~cancel_q;
    out_wdata_q <= cancel_q ? 32'd0 : wdata_q;
    out_ren_q   <= ren_q & ~cancel_q;
    out_rval_q  <= cancel_q ? 32'd0 : rval_q;
  end

  assign done_o           = done_q;
  assign access_address_o = out_addr_q;
  assign access_size_o    = out_size_q;
  assign mem_read_o       = out_rd_q;
  assign mem_write_en_o   = out_wen_q;
  assign mem_write_data_o = out_wdata_q;
  assign reg_write_en_o   = out_ren_q;
  assign reg_value_o      = out_rval_q;

endmodule

@@ hw/rtl/mips_load_store_align_unit_top.sv @@
// mips_load_store_align_unit_top: address stage and top level of the
// load/store align unit; uses lsau_pkg and lsau_datapath
//
//   port group        dir   handshake
//   start/busy + in   in    word taken at clk edge with start high, busy low
//   done_o + results  out   one-cycle strobe, no back-pressure
//
// three register stages: effective address add, decode and byte merge,
// fault masking into the output registers
// a word taken in passes the address, merge and output registers before its result shows
// busy is tied low: one word per clock, every clock
// reset clears the stage valid bits only
`timescale 1ns / 1ps

module mips_load_store_align_unit_top import lsau_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         req_type_i,
  input  logic [31:0]        base_value_i,
  input  logic signed [15:0] offset_i,
  input  logic [31:0]        rt_value_i,
  input  logic [31:0]        mem_data_i,
  input  logic               translation_fault_i,
  output logic               done_o,
  output logic [31:0]        access_address_o,
  output logic [1:0]         access_size_o,
  output logic               mem_read_o,
  output logic               mem_write_en_o,
  output logic [31:0]        mem_write_data_o,
  output logic               reg_write_en_o,
  output logic [31:0]        reg_value_o
);

  logic       valid1_q;
  addr_word_t word1_d, word1_q;

  assign busy = 1'b0;

  always_comb begin
    word1_d.req_type = req_e'(req_type_i);
    word1_d.ea       = base_value_i + {{16{offset_i[15]}}, offset_i};
    word1_d.off16    = offset_i;
    word1_d.rt       = rt_value_i;
    word1_d.mem      = mem_data_i;
    word1_d.fault    = translation_fault_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else begin
      valid1_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    word1_q <= word1_d;
  end

  lsau_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid1_q),
    .word_i           (word1_q),
    .done_o           (done_o),
    .access_address_o (access_address_o),
    .access_size_o    (access_size_o),
    .mem_read_o       (mem_read_o),
    .mem_write_en_o   (mem_write_en_o),
    .mem_write_data_o (mem_write_data_o),
    .reg_write_en_o   (reg_write_en_o),
    .reg_value_o      (reg_value_o)
  );

endmodule
